// ===== rtl/gbn_pkg.sv =====
// Shared types, constants and helpers of the go-back-n sender window.
// No dependencies; every other file of the block imports this package.
package gbn_pkg;

  localparam int WINDOW_SLOTS = 10;
  localparam int MAX_PAYLOAD  = 512;
  localparam int SEQ_MODULUS  = 25601;

  localparam int SEQ_W     = 15;
  localparam int LEN_W     = 10;
  localparam int SLOT_OUT_W = 4;
  localparam int SLOT_W    = $clog2(WINDOW_SLOTS);
  localparam int CNT_W     = $clog2(WINDOW_SLOTS + 1);
  localparam int WIN_BYTES = WINDOW_SLOTS * MAX_PAYLOAD;
  localparam int CUM_W     = $clog2(WIN_BYTES + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // Request types.
  localparam logic [1:0] REQ_CHUNK = 2'd0;
  localparam logic [1:0] REQ_ACK   = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Result actions.
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_SEND   = 3'd1;
  localparam logic [2:0] ACT_RESEND = 3'd2;
  localparam logic [2:0] ACT_REJECT = 3'd3;
  localparam logic [2:0] ACT_TAKEN  = 3'd4;
  localparam logic [2:0] ACT_IGNORE = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ACK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd3;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [LEN_W-1:0] chunk_len;
    logic [SEQ_W-1:0] ack_value;
  } gbn_in_t;

  typedef struct packed {
    logic [2:0]            action;
    logic [SLOT_OUT_W-1:0] slot;
    logic [SEQ_W-1:0]      packet_seq;
    logic [SEQ_W-1:0]      header_ack_num;
    logic                  header_ack_flag;
    logic [LEN_W-1:0]      packet_len;
    logic                  timed_out;
    logic [SEQ_W-1:0]      window_base;
    logic                  all_acked;
    logic                  last;
  } gbn_out_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic             hdr_flag;
    logic [SEQ_W-1:0] hdr_ack;
    logic [31:0]      stamp;
  } gbn_slot_t;

  typedef enum logic [1:0] {
    ALU_MADD,
    ALU_MSUB,
    ALU_SUB32
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CH_CHECK,
    ST_CH_ADV,
    ST_AK_CHECK,
    ST_AK_SCAN,
    ST_AK_COMMIT,
    ST_TK_CHECK,
    ST_TK_RESEND,
    ST_REPLY
  } gbn_state_t;

  // Advance a ring index with wrap.
  function automatic slot_idx_t slot_inc(input slot_idx_t idx);
    slot_idx_t r;
    if (idx == SLOT_W'(WINDOW_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = idx + SLOT_W'(1);
    end
    return r;
  endfunction

  // Fold a raw sequence field into the modulus; one subtract suffices
  // because the modulus exceeds half the field range.
  function automatic logic [SEQ_W-1:0] seq_reduce(input logic [SEQ_W-1:0] x);
    logic [SEQ_W-1:0] r;
    if (32'(x) >= 32'(SEQ_MODULUS)) begin
      r = x - SEQ_W'(SEQ_MODULUS);
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

// ===== rtl/go_back_n_sender_window_core.sv =====
// Top level of the go-back-n sender window: sequencer, state and output register.
// Depends on gbn_pkg, gbn_seq_alu and gbn_slot_file.
//
// The block takes one request at a time: a chunk offer, a cumulative ack or
// a time tick. A small sequencer runs each request through one shared
// modular-arithmetic unit and a ten-entry ring of slot records, then posts
// its results into a single output register, so a result can wait for the
// consumer while the sequencer goes back to idle and takes the next request.
// in_stall is high whenever the sequencer is busy. A chunk is checked and stored,
// then its sequence number advanced, unless it is rejected; an ack that is out of
// range or equal to the window base is ignored at once, otherwise the outstanding
// packets are scanned from the oldest, one ring slot per cycle; a tick that times
// out nothing replies at once, otherwise the outstanding packets are resent oldest
// first, one per cycle while the output is not stalled. Output stalls hold the
// sequencer in its reply and resend states. Slot records need no clearing after
// reset since only outstanding slots are ever read.
module go_back_n_sender_window_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gbn_pkg::gbn_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gbn_pkg::gbn_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbn_pkg::CFG_W-1:0]       cfg_wdata
);
  import gbn_pkg::*;

  gbn_state_t state_r, state_nxt;

  // configuration
  logic [31:0]      total_r, total_nxt;
  logic [SEQ_W-1:0] first_ack_r, first_ack_nxt;
  logic [15:0]      timeout_r, timeout_nxt;

  // window state
  logic [SEQ_W-1:0] base_seq_r, base_seq_nxt;
  slot_idx_t        base_idx_r, base_idx_nxt;
  logic [SEQ_W-1:0] next_seq_r, next_seq_nxt;
  slot_idx_t        next_idx_r, next_idx_nxt;
  logic [CNT_W-1:0] in_flight_r, in_flight_nxt;
  logic [31:0]      bytes_acked_r, bytes_acked_nxt;
  logic [31:0]      bytes_queued_r, bytes_queued_nxt;
  logic [31:0]      now_r, now_nxt;
  logic             first_pend_r, first_pend_nxt;

  // per-request working registers
  gbn_in_t          req_r, req_nxt;
  slot_idx_t        scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0] scan_k_r, scan_k_nxt;
  logic [SEQ_W-1:0] da_r, da_nxt;
  logic [SEQ_W-1:0] cum_mod_r, cum_mod_nxt;
  logic [CUM_W-1:0] cum_r, cum_nxt;
  gbn_out_t         res_r, res_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  gbn_out_t         out_r, out_nxt;

  // shared unit and slot ring hookup
  alu_op_t     alu_op;
  logic [31:0] alu_a, alu_b, alu_res;
  logic        slot_we, stamp_we;
  slot_idx_t   slot_waddr;
  gbn_slot_t   slot_wdata, slot_rd;

  logic in_acc, out_free, emit;
  logic chunk_reject, ack_bad, scan_done, ack_hit, tick_expire, resend_last;

  gbn_seq_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  gbn_slot_file u_slots (
    .clk      (clk),
    .wr_en    (slot_we),
    .stamp_en (stamp_we),
    .wr_addr  (slot_waddr),
    .wr_data  (slot_wdata),
    .rd_addr  (scan_idx_r),
    .rd_data  (slot_rd)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Shared unit operand select: one use per sequencer state.
  always_comb begin
    alu_op = ALU_MADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_r)
      ST_CH_CHECK: begin
        alu_op = ALU_MSUB;
        alu_a  = 32'(next_seq_r);
        alu_b  = 32'(base_seq_r);
      end
      ST_CH_ADV: begin
        alu_op = ALU_MADD;
        alu_a  = 32'(next_seq_r);
        alu_b  = 32'(req_r.chunk_len);
      end
      ST_AK_CHECK: begin
        alu_op = ALU_MSUB;
        alu_a  = 32'(req_r.ack_value);
        alu_b  = 32'(base_seq_r);
      end
      ST_AK_SCAN: begin
        alu_op = ALU_MADD;
        alu_a  = 32'(cum_mod_r);
        alu_b  = 32'(slot_rd.len);
      end
      ST_TK_CHECK: begin
        alu_op = ALU_SUB32;
        alu_a  = now_r;
        alu_b  = slot_rd.stamp;
      end
      default: begin
        alu_op = ALU_MADD;
      end
    endcase
  end

  // Decisions taken from the shared unit's result.
  always_comb begin
    chunk_reject = (req_r.chunk_len == '0)
                || (32'(req_r.chunk_len) > 32'(MAX_PAYLOAD))
                || (bytes_queued_r >= total_r)
                || (32'(in_flight_r) >= 32'(WINDOW_SLOTS))
                || (alu_res >= 32'(WIN_BYTES));
    ack_bad      = (32'(req_r.ack_value) >= 32'(SEQ_MODULUS)) || (alu_res == '0);
    scan_done    = (scan_k_r >= in_flight_r);
    ack_hit      = (alu_res[SEQ_W-1:0] == da_r);
    tick_expire  = (in_flight_r != '0) && (alu_res > 32'(timeout_r));
    resend_last  = ((scan_k_r + CNT_W'(1)) == in_flight_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.req_type)
            REQ_CHUNK: state_nxt = ST_CH_CHECK;
            REQ_ACK:   state_nxt = ST_AK_CHECK;
            REQ_TICK:  state_nxt = ST_TK_CHECK;
            default:   state_nxt = ST_REPLY;
          endcase
        end
      end
      ST_CH_CHECK:  state_nxt = chunk_reject ? ST_REPLY : ST_CH_ADV;
      ST_CH_ADV:    state_nxt = ST_REPLY;
      ST_AK_CHECK:  state_nxt = ack_bad ? ST_REPLY : ST_AK_SCAN;
      ST_AK_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_REPLY;
        end else if (ack_hit) begin
          state_nxt = ST_AK_COMMIT;
        end
      end
      ST_AK_COMMIT: state_nxt = ST_REPLY;
      ST_TK_CHECK:  state_nxt = tick_expire ? ST_TK_RESEND : ST_REPLY;
      ST_TK_RESEND: begin
        if (out_free && resend_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, slot ring writes and result posting.
  always_comb begin
    total_nxt        = total_r;
    first_ack_nxt    = first_ack_r;
    timeout_nxt      = timeout_r;
    base_seq_nxt     = base_seq_r;
    base_idx_nxt     = base_idx_r;
    next_seq_nxt     = next_seq_r;
    next_idx_nxt     = next_idx_r;
    in_flight_nxt    = in_flight_r;
    bytes_acked_nxt  = bytes_acked_r;
    bytes_queued_nxt = bytes_queued_r;
    now_nxt          = now_r;
    first_pend_nxt   = first_pend_r;
    req_nxt          = req_r;
    scan_idx_nxt     = scan_idx_r;
    scan_k_nxt       = scan_k_r;
    da_nxt           = da_r;
    cum_mod_nxt      = cum_mod_r;
    cum_nxt          = cum_r;
    res_nxt          = res_r;
    out_nxt          = out_r;
    emit             = 1'b0;

    slot_we          = 1'b0;
    stamp_we         = 1'b0;
    slot_waddr       = next_idx_r;
    slot_wdata.seq      = next_seq_r;
    slot_wdata.len      = req_r.chunk_len;
    slot_wdata.hdr_flag = first_pend_r;
    slot_wdata.hdr_ack  = first_pend_r ? first_ack_r : '0;
    slot_wdata.stamp    = now_r;

    // The user must write configuration only while idle; the block does not enforce it.
    if (cfg_we) begin
      case (cfg_index)
        CFG_TOTAL_BYTES: total_nxt = cfg_wdata;
        CFG_START_SEQ: begin
          // reload the window only with nothing outstanding
          if (in_flight_r == '0) begin
            base_seq_nxt = seq_reduce(cfg_wdata[SEQ_W-1:0]);
            next_seq_nxt = seq_reduce(cfg_wdata[SEQ_W-1:0]);
          end
        end
        CFG_FIRST_ACK: first_ack_nxt = seq_reduce(cfg_wdata[SEQ_W-1:0]);
        CFG_TIMEOUT:   timeout_nxt   = cfg_wdata[15:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt      = in_data;
          scan_idx_nxt = base_idx_r;
          scan_k_nxt   = '0;
          cum_nxt      = '0;
          cum_mod_nxt  = '0;
          res_nxt      = '0;
          res_nxt.action = ACT_NONE;
          if (in_data.req_type == REQ_TICK) begin
            now_nxt = now_r + 32'd1;
          end
        end
      end

      ST_CH_CHECK: begin
        if (chunk_reject) begin
          res_nxt.action = ACT_REJECT;
        end else begin
          // store the packet, hand out its slot, and book it in flight
          slot_we                 = 1'b1;
          res_nxt.action          = ACT_SEND;
          res_nxt.slot            = SLOT_OUT_W'(next_idx_r);
          res_nxt.packet_seq      = next_seq_r;
          res_nxt.header_ack_num  = slot_wdata.hdr_ack;
          res_nxt.header_ack_flag = first_pend_r;
          res_nxt.packet_len      = req_r.chunk_len;
          first_pend_nxt          = 1'b0;
          next_idx_nxt            = slot_inc(next_idx_r);
          in_flight_nxt           = in_flight_r + CNT_W'(1);
          bytes_queued_nxt        = bytes_queued_r + 32'(req_r.chunk_len);
        end
      end

      ST_CH_ADV: begin
        next_seq_nxt = alu_res[SEQ_W-1:0];
      end

      ST_AK_CHECK: begin
        da_nxt = alu_res[SEQ_W-1:0];
        if (ack_bad) begin
          res_nxt.action = ACT_IGNORE;
        end
      end

      ST_AK_SCAN: begin
        // walk outstanding packets from the oldest, one per cycle, until the running
        // byte count lands on the ack distance or all of them are scanned
        if (scan_done) begin
          res_nxt.action = ACT_IGNORE;
        end else begin
          cum_mod_nxt  = alu_res[SEQ_W-1:0];
          cum_nxt      = cum_r + CUM_W'(slot_rd.len);
          scan_k_nxt   = scan_k_r + CNT_W'(1);
          scan_idx_nxt = slot_inc(scan_idx_r);
          if (ack_hit) begin
            base_idx_nxt   = slot_inc(scan_idx_r);
            in_flight_nxt  = in_flight_r - scan_k_r - CNT_W'(1);
            res_nxt.action = ACT_TAKEN;
          end
        end
      end

      ST_AK_COMMIT: begin
        bytes_acked_nxt = bytes_acked_r + 32'(cum_r);
        base_seq_nxt    = req_r.ack_value;
      end

      ST_TK_CHECK: begin
        if (!tick_expire) begin
          res_nxt.action = ACT_NONE;
        end
      end

      ST_TK_RESEND: begin
        // resend one slot per free output cycle, oldest first; restamp it
        if (out_free) begin
          emit                    = 1'b1;
          stamp_we                = 1'b1;
          slot_waddr              = scan_idx_r;
          out_nxt.action          = ACT_RESEND;
          out_nxt.slot            = SLOT_OUT_W'(scan_idx_r);
          out_nxt.packet_seq      = slot_rd.seq;
          out_nxt.header_ack_num  = slot_rd.hdr_ack;
          out_nxt.header_ack_flag = slot_rd.hdr_flag;
          out_nxt.packet_len      = slot_rd.len;
          out_nxt.timed_out       = 1'b1;
          out_nxt.window_base     = base_seq_r;
          out_nxt.all_acked       = (bytes_acked_r == total_r);
          out_nxt.last            = resend_last;
          scan_k_nxt              = scan_k_r + CNT_W'(1);
          scan_idx_nxt            = slot_inc(scan_idx_r);
        end
      end

      ST_REPLY: begin
        if (out_free) begin
          emit                = 1'b1;
          out_nxt             = res_r;
          out_nxt.timed_out   = 1'b0;
          out_nxt.window_base = base_seq_r;
          out_nxt.all_acked   = (bytes_acked_r == total_r);
          out_nxt.last        = 1'b1;
        end
      end

      default: ;
    endcase

    // Hold the result while stalled; drop it once taken.
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      total_r        <= '0;
      first_ack_r    <= '0;
      timeout_r      <= 16'd500;
      base_seq_r     <= '0;
      base_idx_r     <= '0;
      next_seq_r     <= '0;
      next_idx_r     <= '0;
      in_flight_r    <= '0;
      bytes_acked_r  <= '0;
      bytes_queued_r <= '0;
      now_r          <= '0;
      first_pend_r   <= 1'b1;
      scan_idx_r     <= '0;
      scan_k_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      total_r        <= total_nxt;
      first_ack_r    <= first_ack_nxt;
      timeout_r      <= timeout_nxt;
      base_seq_r     <= base_seq_nxt;
      base_idx_r     <= base_idx_nxt;
      next_seq_r     <= next_seq_nxt;
      next_idx_r     <= next_idx_nxt;
      in_flight_r    <= in_flight_nxt;
      bytes_acked_r  <= bytes_acked_nxt;
      bytes_queued_r <= bytes_queued_nxt;
      now_r          <= now_nxt;
      first_pend_r   <= first_pend_nxt;
      scan_idx_r     <= scan_idx_nxt;
      scan_k_r       <= scan_k_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    da_r      <= da_nxt;
    cum_mod_r <= cum_mod_nxt;
    cum_r     <= cum_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ===== rtl/gbn_seq_alu.sv =====
// Shared arithmetic unit: modular add/subtract over the sequence space
// and a plain 32-bit subtract. Depends on gbn_pkg.
module gbn_seq_alu (
  input  gbn_pkg::alu_op_t op,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output logic [31:0]      res
);
  import gbn_pkg::*;

  logic [SEQ_W:0]   sum;
  logic [SEQ_W:0]   diff;
  logic [SEQ_W-1:0] wrap;

  always_comb begin
    sum  = {1'b0, a[SEQ_W-1:0]} + {1'b0, b[SEQ_W-1:0]};
    diff = {1'b0, a[SEQ_W-1:0]} - {1'b0, b[SEQ_W-1:0]};
    wrap = diff[SEQ_W-1:0] + SEQ_W'(SEQ_MODULUS);
    case (op)
      ALU_MADD: begin
        if (32'(sum) >= 32'(SEQ_MODULUS)) begin
          res = 32'(sum - (SEQ_W + 1)'(SEQ_MODULUS));
        end else begin
          res = 32'(sum);
        end
      end
      ALU_MSUB: begin
        // borrow out means the distance wrapped; add the modulus back
        if (diff[SEQ_W]) begin
          res = 32'(wrap);
        end else begin
          res = 32'(diff[SEQ_W-1:0]);
        end
      end
      ALU_SUB32: res = a - b;
      default:   res = '0;
    endcase
  end

endmodule

// ===== rtl/gbn_slot_file.sv =====
// Ring of outstanding packet records, one per window slot.
// One write port (full record or time stamp only), one read port. Depends on gbn_pkg.
module gbn_slot_file (
  input  logic                clk,
  input  logic                wr_en,
  input  logic                stamp_en,
  input  gbn_pkg::slot_idx_t  wr_addr,
  input  gbn_pkg::gbn_slot_t  wr_data,
  input  gbn_pkg::slot_idx_t  rd_addr,
  output gbn_pkg::gbn_slot_t  rd_data
);
  import gbn_pkg::*;

  gbn_slot_t   rec_r   [WINDOW_SLOTS];
  logic [31:0] stamp_r [WINDOW_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_r[wr_addr] <= wr_data;
    end
    if (wr_en || stamp_en) begin
      stamp_r[wr_addr] <= wr_data.stamp;
    end
  end

  always_comb begin
    rd_data       = rec_r[rd_addr];
    rd_data.stamp = stamp_r[rd_addr];
  end

endmodule

// ===== verif/gbn_window_checker.sv =====
// Checker for the go-back-n sender window: tracks the window state on every accepted
// request and register write, and compares each accepted result with its prediction.
// Depends on gbn_pkg for the payload structs, actions, request types and register indexes.
module gbn_window_checker (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  input  logic                                          in_stall,
  input  gbn_pkg::gbn_in_t                              in_data,
  input  logic                                          out_valid,
  input  logic                                          out_stall,
  input  gbn_pkg::gbn_out_t                             out_data,
  input  logic                                          cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  logic [gbn_pkg::CFG_W-1:0]                     cfg_wdata,
  output int                                            fail_count,
  output int                                            pending,
  output logic [gbn_pkg::SEQ_W-1:0]                     hint_base,
  output logic [gbn_pkg::CNT_W-1:0]                     hint_unacked,
  output logic [gbn_pkg::WINDOW_SLOTS*gbn_pkg::SEQ_W-1:0] hint_ack_pts,
  output logic [31:0]                                   hint_queued
);
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  // Register copies.
  logic [31:0]      cfg_total;
  logic [SEQ_W-1:0] cfg_start;
  logic [SEQ_W-1:0] cfg_first_ack;
  logic [15:0]      cfg_timeout;

  // Window state.
  gbn_slot_t        ring [WINDOW_SLOTS];
  logic [SEQ_W-1:0] win_lo;
  logic [SEQ_W-1:0] win_hi;
  int               head_slot;
  int               tail_slot;
  int               unacked;
  logic [31:0]      acked_total;
  logic [31:0]      queued_total;
  logic [31:0]      tick_count;
  logic             first_unsent;

  gbn_out_t due_results [$];

  function automatic int seq_gap(input int from, input int to);
    return (to + SEQ_MODULUS - from) % SEQ_MODULUS;
  endfunction

  function automatic gbn_out_t pack_result(input logic [2:0] act, input int slot,
                                           input gbn_slot_t rec, input logic tmo,
                                           input logic fin);
    gbn_out_t r;
    r.action          = act;
    r.slot            = SLOT_OUT_W'(slot);
    r.packet_seq      = rec.seq;
    r.header_ack_num  = rec.hdr_ack;
    r.header_ack_flag = rec.hdr_flag;
    r.packet_len      = rec.len;
    r.timed_out       = tmo;
    r.window_base     = win_lo;
    r.all_acked       = (acked_total == cfg_total);
    r.last            = fin;
    return r;
  endfunction

  function automatic void reset_model();
    foreach (ring[i]) ring[i] = '0;
    cfg_total     = '0;
    cfg_start     = '0;
    cfg_first_ack = '0;
    cfg_timeout   = 16'd500;
    win_lo        = '0;
    win_hi        = '0;
    head_slot     = 0;
    tail_slot     = 0;
    unacked       = 0;
    acked_total   = '0;
    queued_total  = '0;
    tick_count    = '0;
    first_unsent  = 1'b1;
    due_results.delete();
    fail_count    = 0;
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    case (idx)
      CFG_TOTAL_BYTES: cfg_total = val;
      CFG_START_SEQ: begin
        cfg_start = val[SEQ_W-1:0];
        // the window only moves when nothing is outstanding
        if (unacked == 0) begin
          win_lo = SEQ_W'(int'(cfg_start) % SEQ_MODULUS);
          win_hi = win_lo;
        end
      end
      CFG_FIRST_ACK: cfg_first_ack = val[SEQ_W-1:0];
      CFG_TIMEOUT:   cfg_timeout = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic void step_window(input gbn_in_t req);
    gbn_slot_t   rec;
    int          cum;
    int          hit;
    int          ack_gap;
    int          idx;
    int          k;
    logic [31:0] waited;
    rec = '0;
    case (req.req_type)
      REQ_CHUNK: begin
        if (req.chunk_len == 0 || req.chunk_len > MAX_PAYLOAD ||
            queued_total >= cfg_total || unacked >= WINDOW_SLOTS ||
            seq_gap(int'(win_lo), int'(win_hi)) >= WIN_BYTES) begin
          due_results.push_back(pack_result(ACT_REJECT, 0, rec, 1'b0, 1'b1));
        end else begin
          rec.seq      = win_hi;
          rec.len      = req.chunk_len;
          rec.hdr_flag = first_unsent;
          rec.hdr_ack  = first_unsent ? SEQ_W'(int'(cfg_first_ack) % SEQ_MODULUS) : '0;
          rec.stamp    = tick_count;
          idx          = tail_slot;
          ring[idx]    = rec;
          first_unsent = 1'b0;
          win_hi       = SEQ_W'((int'(win_hi) + int'(req.chunk_len)) % SEQ_MODULUS);
          tail_slot    = (tail_slot + 1) % WINDOW_SLOTS;
          unacked++;
          queued_total = queued_total + 32'(req.chunk_len);
          due_results.push_back(pack_result(ACT_SEND, idx, rec, 1'b0, 1'b1));
        end
      end
      REQ_ACK: begin
        hit = 0;
        cum = 0;
        if (req.ack_value < SEQ_MODULUS) begin
          ack_gap = seq_gap(int'(win_lo), int'(req.ack_value));
          if (ack_gap != 0) begin
            for (k = 0; k < unacked; k++) begin
              cum += int'(ring[(head_slot + k) % WINDOW_SLOTS].len);
              if (cum == ack_gap) begin
                hit = k + 1;
                break;
              end
            end
          end
        end
        if (hit == 0) begin
          due_results.push_back(pack_result(ACT_IGNORE, 0, rec, 1'b0, 1'b1));
        end else begin
          acked_total = acked_total + 32'(cum);
          win_lo      = req.ack_value;
          head_slot   = (head_slot + hit) % WINDOW_SLOTS;
          unacked     -= hit;
          due_results.push_back(pack_result(ACT_TAKEN, 0, rec, 1'b0, 1'b1));
        end
      end
      REQ_TICK: begin
        tick_count = tick_count + 32'd1;
        waited = (unacked == 0) ? '0 : tick_count - ring[head_slot].stamp;
        if (unacked == 0 || waited <= 32'(cfg_timeout)) begin
          due_results.push_back(pack_result(ACT_NONE, 0, rec, 1'b0, 1'b1));
        end else begin
          for (k = 0; k < unacked; k++) begin
            idx = (head_slot + k) % WINDOW_SLOTS;
            ring[idx].stamp = tick_count;
            due_results.push_back(pack_result(ACT_RESEND, idx, ring[idx], 1'b1,
                                              k == unacked - 1));
          end
        end
      end
      default: due_results.push_back(pack_result(ACT_NONE, 0, rec, 1'b0, 1'b1));
    endcase
  endfunction

  function automatic void field_ok(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(input gbn_out_t got);
    gbn_out_t want;
    if (due_results.size() == 0) begin
      $error("result with no request behind it: action %0d", got.action);
      fail_count++;
    end else begin
      want = due_results.pop_front();
      field_ok("action", want.action, got.action);
      field_ok("slot", want.slot, got.slot);
      field_ok("packet_seq", want.packet_seq, got.packet_seq);
      field_ok("header_ack_num", want.header_ack_num, got.header_ack_num);
      field_ok("header_ack_flag", want.header_ack_flag, got.header_ack_flag);
      field_ok("packet_len", want.packet_len, got.packet_len);
      field_ok("timed_out", want.timed_out, got.timed_out);
      field_ok("window_base", want.window_base, got.window_base);
      field_ok("all_acked", want.all_acked, got.all_acked);
      field_ok("last", want.last, got.last);
    end
  endfunction

  function automatic void refresh_hints();
    int cum;
    int k;
    cum = 0;
    for (k = 0; k < WINDOW_SLOTS; k++) begin
      if (k < unacked) begin
        cum += int'(ring[(head_slot + k) % WINDOW_SLOTS].len);
        hint_ack_pts[k*SEQ_W +: SEQ_W] = SEQ_W'((int'(win_lo) + cum) % SEQ_MODULUS);
      end else begin
        hint_ack_pts[k*SEQ_W +: SEQ_W] = '0;
      end
    end
    hint_base    = win_lo;
    hint_unacked = CNT_W'(unacked);
    hint_queued  = queued_total;
    pending      = due_results.size();
  endfunction

  // Compare first: a result leaving at this edge never stems from a request taken now.
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (cfg_we) write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) step_window(in_data);
    end
    refresh_hints();
  end

endmodule

// ===== verif/tb_go_back_n_sender_window_core.sv =====
// Testbench top of the go-back-n sender window: clock, reset, request and register
// stimulus, output backpressure and the verdict. Depends on gbn_pkg, the block under
// test and gbn_window_checker, which predicts and compares every result.
module tb_go_back_n_sender_window_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  // Request type with no meaning to the block; it must answer with one empty result.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  gbn_in_t                       in_data;
  logic                          out_valid;
  logic                          out_stall;
  gbn_out_t                      out_data;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_W-1:0]              cfg_wdata;

  int                            fail_count;
  int                            pending;
  logic [SEQ_W-1:0]              hint_base;
  logic [CNT_W-1:0]              hint_unacked;
  logic [WINDOW_SLOTS*SEQ_W-1:0] hint_ack_pts;
  logic [31:0]                   hint_queued;

  // Random idling on both channels while set; cleared for the closing stretch.
  bit idle_on = 1'b1;

  always #1ns clk = ~clk;

  go_back_n_sender_window_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gbn_window_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .hint_base    (hint_base),
    .hint_unacked (hint_unacked),
    .hint_ack_pts (hint_ack_pts),
    .hint_queued  (hint_queued)
  );

  function automatic gbn_in_t request_of(input logic [1:0] req, input int len, input int ack);
    gbn_in_t r;
    r.req_type  = req;
    r.chunk_len = LEN_W'(len);
    r.ack_value = SEQ_W'(ack);
    return r;
  endfunction

  // Sequence number that ends the k-th outstanding packet, counted from the oldest.
  function automatic int ack_point(input int k);
    return int'(hint_ack_pts[k*SEQ_W +: SEQ_W]);
  endfunction

  // Come back at a falling edge, after a random hold-off with valid low now and then.
  // The checker hints are current from here until the request is presented.
  task automatic await_turn();
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drive one request and hold it until the block takes it. Valid stays high on
  // return so that a back-to-back request just replaces the payload.
  task automatic present(input gbn_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic push_request(input logic [1:0] req, input int len, input int ack);
    await_turn();
    present(request_of(req, len, ack));
  endtask

  // Hold the sender until every predicted result has come out, then let the
  // sequencer run down before anything touches the registers.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random request. Acks mostly land on a real packet boundary so that the
  // window keeps moving; the rest hit the base, overflow or land anywhere.
  task automatic random_request(input int chunk_pct);
    int r;
    int c;
    int len;
    int ack;
    logic [1:0] req;
    await_turn();
    r   = $urandom_range(0, 99);
    len = $urandom_range(0, 1023);
    ack = $urandom_range(0, 32767);
    if (r < chunk_pct) begin
      req = REQ_CHUNK;
      c = $urandom_range(0, 19);
      if (c == 0) len = 0;
      else if (c < 3) len = $urandom_range(MAX_PAYLOAD + 1, 1023);
      else len = $urandom_range(1, MAX_PAYLOAD);
    end else begin
      c = $urandom_range(0, 19);
      if (c == 0) begin
        req = REQ_UNUSED;
      end else if (c < 12) begin
        req = REQ_ACK;
        c = $urandom_range(0, 9);
        if (hint_unacked != 0 && c < 7) ack = ack_point($urandom_range(0, int'(hint_unacked) - 1));
        else if (c == 7) ack = int'(hint_base);
        else if (c == 8) ack = $urandom_range(SEQ_MODULUS, 32767);
        else ack = $urandom_range(0, SEQ_MODULUS - 1);
      end else begin
        req = REQ_TICK;
      end
    end
    present(request_of(req, len, ack));
  endtask

  task automatic random_phase(input int count, input int chunk_pct);
    repeat (count) random_request(chunk_pct);
  endtask

  // Output backpressure in random bursts while idling is on.
  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #1ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: nothing to transfer, so every chunk bounces and the
    // completion flag is already up.
    push_request(REQ_CHUNK, 100, 32767);
    push_request(REQ_TICK, 0, 0);              // tick with an empty window
    push_request(REQ_UNUSED, 1023, 32767);
    push_request(REQ_ACK, 1023, 0);            // ack on the window base
    push_request(REQ_ACK, 0, 32767);           // ack past the sequence space
    drain();

    // Start right at the top of the sequence space so the first packets wrap.
    reg_write(CFG_TOTAL_BYTES, 32'hFFFF_FFFF);
    reg_write(CFG_START_SEQ, 32'(SEQ_MODULUS - 1));
    reg_write(CFG_FIRST_ACK, 32'h0000_7FFF);
    reg_write(CFG_TIMEOUT, 32'd1);

    push_request(REQ_CHUNK, 0, 0);
    push_request(REQ_CHUNK, MAX_PAYLOAD + 1, 0);
    push_request(REQ_CHUNK, 1023, 0);
    push_request(REQ_CHUNK, MAX_PAYLOAD, 0);   // first packet carries the header ack
    push_request(REQ_CHUNK, 1, 0);
    repeat (8) push_request(REQ_CHUNK, $urandom_range(1, MAX_PAYLOAD), $urandom);
    push_request(REQ_CHUNK, 300, 0);           // ring full
    // one byte short of the first packet end: not a boundary
    await_turn();
    present(request_of(REQ_ACK, 0, (ack_point(0) + SEQ_MODULUS - 1) % SEQ_MODULUS));
    push_request(REQ_TICK, 0, 0);
    push_request(REQ_TICK, 0, 0);              // full window resend
    await_turn();
    present(request_of(REQ_ACK, 0, ack_point(0)));
    await_turn();
    present(request_of(REQ_ACK, 0, ack_point(int'(hint_unacked) - 1)));
    push_request(REQ_TICK, 0, 0);
    drain();

    reg_write(CFG_TIMEOUT, 32'd3);
    random_phase(24, 45);
    drain();

    // Move the start while packets may still be out; the window must stay put then.
    reg_write(CFG_TIMEOUT, 32'd65535);
    reg_write(CFG_START_SEQ, 32'($urandom_range(0, 32767)));
    random_phase(20, 45);
    drain();

    // Retire everything, then restart the sequence space at zero.
    if (hint_unacked != 0) begin
      await_turn();
      present(request_of(REQ_ACK, 0, ack_point(int'(hint_unacked) - 1)));
      drain();
    end
    reg_write(CFG_START_SEQ, 32'd0);
    reg_write(CFG_FIRST_ACK, 32'($urandom_range(0, 32767)));
    reg_write(CFG_TIMEOUT, 32'($urandom_range(1, 8)));
    reg_write(CFG_TOTAL_BYTES, $urandom);
    random_phase(20, 45);
    drain();

    // A transfer size just ahead of what is queued, so chunks start to bounce.
    reg_write(CFG_TOTAL_BYTES, hint_queued + 32'($urandom_range(600, 2500)));
    reg_write(CFG_TIMEOUT, 32'd2);
    random_phase(20, 45);
    drain();

    // Close the transfer at what is queued and ack it out, with no idling.
    reg_write(CFG_TOTAL_BYTES, hint_queued);
    idle_on = 1'b0;
    random_phase(20, 20);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== go_back_n_sender_window_core.f =====
rtl/gbn_pkg.sv
rtl/gbn_seq_alu.sv
rtl/gbn_slot_file.sv
rtl/go_back_n_sender_window_core.sv
verif/gbn_window_checker.sv
verif/tb_go_back_n_sender_window_core.sv
